### rtl/uvs_pkg.sv
package uvs_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_CELLS  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int DIV_CELLS     = 32;
    localparam int LAST_SLOT     = 5;
    localparam int LAST_CORNER   = 5;

    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_LAYERS = 2'd2;

    typedef enum logic [1:0] {
        TAG_LAYER0,
        TAG_LAYER1,
        TAG_SLICE0,
        TAG_SLICE1
    } t_tag;

    typedef struct packed {
        logic valid;
        t_tag tag;
        logic err;
    } t_token;

    typedef struct packed {
        logic        valid;
        logic [2:0]  corner;
        logic        last;
        logic        err;
    } t_meta;

    function automatic logic signed [31:0] atan_turn(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // corners in order: (L,S) (L,S+1) (L+1,S+1) (L,S) (L+1,S+1) (L+1,S)
    function automatic logic corner_layer_hi(input logic [2:0] c);
        return (c == 3'd2) || (c == 3'd4) || (c == 3'd5);
    endfunction

    function automatic logic corner_slice_hi(input logic [2:0] c);
        return (c == 3'd1) || (c == 3'd2) || (c == 3'd4);
    endfunction

endpackage

### rtl/uvs_div_cell.sv
module uvs_div_cell
    import uvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_token      i_tok,
    input  logic [9:0]  i_rem,
    input  logic [9:0]  i_den,
    input  logic [31:0] i_q,
    output t_token      o_tok,
    output logic [9:0]  o_rem,
    output logic [9:0]  o_den,
    output logic [31:0] o_q
);

    t_token      r_tok;
    logic [9:0]  r_rem;
    logic [9:0]  r_den;
    logic [31:0] r_q;
    logic [10:0] w_r2;
    logic        w_ge;
    logic [9:0]  n_rem;

    always_comb begin
        w_r2  = {i_rem, 1'b0};
        w_ge  = w_r2 >= {1'b0, i_den};
        n_rem = w_ge ? 10'(w_r2 - {1'b0, i_den}) : 10'(w_r2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= {i_q[30:0], w_ge};
        end
    end

    assign o_tok = r_tok;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

### rtl/uvs_cordic_cell.sv
module uvs_cordic_cell
    import uvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [4:0]         i_stage,
    input  t_token             i_tok,
    input  logic signed [32:0] i_x,
    input  logic signed [32:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic [1:0]         i_quad,
    output t_token             o_tok,
    output logic signed [32:0] o_x,
    output logic signed [32:0] o_y,
    output logic signed [31:0] o_z,
    output logic [1:0]         o_quad
);

    t_token             r_tok;
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [31:0] r_z;
    logic [1:0]         r_quad;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic signed [32:0] n_x;
    logic signed [32:0] n_y;
    logic signed [31:0] n_z;

    always_comb begin
        w_dx = i_x >>> i_stage;
        w_dy = i_y >>> i_stage;
        if (!i_z[31]) begin
            n_x = i_x - w_dy;
            n_y = i_y + w_dx;
            n_z = i_z - atan_turn(i_stage);
        end else begin
            n_x = i_x + w_dy;
            n_y = i_y - w_dx;
            n_z = i_z + atan_turn(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_quad <= i_quad;
        end
    end

    assign o_tok  = r_tok;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_quad = r_quad;

endmodule

### rtl/uv_sphere_cell_vertex_generator_unit.sv
// channel | dir | tdata / tuser / tlast
// s       | in  | tdata: layer_index[7:0], slice_index[15:8]
// m       | out | tdata: pos_x, pos_y, pos_z, normal_x/y/z, corner_number; tuser: range_error;
//         |     | tlast: last_corner
// cfg     | in  | i_cfg_addr 0 radius, 1 slice count, 2 layer count
// A new cell is taken only at slot 0 of the slot counter and yields six items (one if it is out
// of range), one per cycle while the output does not stall; the slot counter feeds four phase
// divisions per cell through the shared divider and CORDIC chains, then the product stages.
// A stall on the output side stops every chain once the skid stage is full.
// Synchronous reset clears all valid bits and the configuration to radius 1.0 and 16 x 16 cells.
module uv_sphere_cell_vertex_generator_unit
    import uvs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [15:0]  i_s_tdata,   // layer_index[7:0], slice_index[15:8]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // pos_x[16:0] pos_y[33:17] pos_z[50:34] normal_x[66:51] normal_y[82:67]
    // normal_z[98:83] corner_number[101:99], zero fill [103:102]
    output logic [103:0] o_m_tdata,
    output logic         o_m_tuser,   // range_error[0]
    output logic         o_m_tlast
);

    typedef struct packed {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [2:0]         corner;
        logic               last;
        logic               err;
    } t_result;

    function automatic logic signed [15:0] norm_of(input logic signed [32:0] u);
        logic signed [33:0] t;
        logic signed [17:0] r;
        t = 34'(u) + 34'sd32768;
        r = 18'(t >>> 16);
        if (r > 18'sd16384) begin
            return 16'sd16384;
        end else if (r < -18'sd16384) begin
            return -16'sd16384;
        end
        return 16'(r);
    endfunction

    function automatic logic signed [16:0] pos_of(input logic signed [49:0] p);
        logic signed [50:0] t;
        logic signed [20:0] r;
        t = 51'(p) + 51'sd536870912;
        r = 21'(t >>> 30);
        if (r > 21'sd65535) begin
            return 17'sd65535;
        end else if (r < -21'sd65535) begin
            return -17'sd65535;
        end
        return 17'(r);
    endfunction

    // configuration
    logic [15:0] r_radius;
    logic [8:0]  r_slices;
    logic [8:0]  r_layers;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd256;
            r_slices <= 9'd16;
            r_layers <= 9'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_RADIUS) begin
                r_radius <= i_cfg_wdata;
            end
            if (i_cfg_addr == REG_SLICES) begin
                r_slices <= i_cfg_wdata[8:0];
            end
            if (i_cfg_addr == REG_LAYERS) begin
                r_layers <= i_cfg_wdata[8:0];
            end
        end
    end

    // flow control
    logic       w_adv;
    logic       w_acc;
    logic       r_skid_v;
    t_result    r_skid;
    logic       r_out_v;
    t_result    r_out;
    logic [2:0] r_slot;

    assign w_adv      = !r_skid_v;
    assign o_s_tready = w_adv && (r_slot == 3'd0);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // slot sequencer: four division tokens, then two empty slots
    logic [7:0] r_layer;
    logic [7:0] r_slice;
    logic       r_err;
    logic       w_in_err;
    t_token     w_inj;
    logic [7:0] w_lay;
    logic [7:0] w_sli;
    logic [8:0] w_num;
    logic [9:0] w_den;
    logic [9:0] w_rem0;

    assign w_in_err = ({1'b0, i_s_tdata[7:0]} >= r_layers)
                   || ({1'b0, i_s_tdata[15:8]} >= r_slices);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 3'd0;
        end else if (w_adv) begin
            if (r_slot == 3'd0) begin
                r_slot <= w_acc ? 3'd1 : 3'd0;
            end else if (r_slot == 3'(LAST_SLOT)) begin
                r_slot <= 3'd0;
            end else begin
                r_slot <= r_slot + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_layer <= i_s_tdata[7:0];
            r_slice <= i_s_tdata[15:8];
            r_err   <= w_in_err;
        end
    end

    always_comb begin
        w_lay = (r_slot == 3'd0) ? i_s_tdata[7:0] : r_layer;
        w_sli = (r_slot == 3'd0) ? i_s_tdata[15:8] : r_slice;
        w_inj = '0;
        w_num = '0;
        w_den = '0;
        unique case (r_slot)
            3'd0: begin
                w_inj = '{valid: w_acc, tag: TAG_LAYER0, err: w_in_err};
                w_num = {1'b0, w_lay};
                w_den = {r_layers, 1'b0};
            end
            3'd1: begin
                w_inj = '{valid: 1'b1, tag: TAG_LAYER1, err: r_err};
                w_num = {1'b0, w_lay} + 9'd1;
                w_den = {r_layers, 1'b0};
            end
            3'd2: begin
                w_inj = '{valid: 1'b1, tag: TAG_SLICE0, err: r_err};
                w_num = {1'b0, w_sli};
                w_den = {1'b0, r_slices};
            end
            3'd3: begin
                w_inj = '{valid: 1'b1, tag: TAG_SLICE1, err: r_err};
                w_num = {1'b0, w_sli} + 9'd1;
                w_den = {1'b0, r_slices};
            end
            default: begin
                w_inj = '0;
            end
        endcase
        // top quotient bit only clears the remainder; phase keeps the low 32 bits
        w_rem0 = ({1'b0, w_num} >= w_den) ? ({1'b0, w_num} - w_den) : {1'b0, w_num};
    end

    // divider chain: phase = num * 2^32 / den
    t_token      w_dtok [0:DIV_CELLS];
    logic [9:0]  w_drem [0:DIV_CELLS];
    logic [9:0]  w_dden [0:DIV_CELLS];
    logic [31:0] w_dq   [0:DIV_CELLS];
    t_token      r_d0_tok;
    logic [9:0]  r_d0_rem;
    logic [9:0]  r_d0_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_tok <= '0;
        end else if (w_adv) begin
            r_d0_tok <= w_inj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d0_rem <= w_rem0;
            r_d0_den <= w_den;
        end
    end

    assign w_dtok[0] = r_d0_tok;
    assign w_drem[0] = r_d0_rem;
    assign w_dden[0] = r_d0_den;
    assign w_dq[0]   = '0;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        uvs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_tok   (w_dtok[g]),
            .i_rem   (w_drem[g]),
            .i_den   (w_dden[g]),
            .i_q     (w_dq[g]),
            .o_tok   (w_dtok[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_den   (w_dden[g+1]),
            .o_q     (w_dq[g+1])
        );
    end

    // quadrant split, residual within an eighth of a turn
    t_token             r_c0_tok;
    logic signed [31:0] r_c0_z;
    logic [1:0]         r_c0_quad;
    logic [31:0]        w_phase;

    assign w_phase = w_dq[DIV_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_tok <= '0;
        end else if (w_adv) begin
            r_c0_tok <= w_dtok[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c0_z    <= 32'(signed'(w_phase[29:0]));
            r_c0_quad <= w_phase[31:30] + {1'b0, w_phase[29]};
        end
    end

    t_token             w_ctok  [0:CORDIC_CELLS];
    logic signed [32:0] w_cx    [0:CORDIC_CELLS];
    logic signed [32:0] w_cy    [0:CORDIC_CELLS];
    logic signed [31:0] w_cz    [0:CORDIC_CELLS];
    logic [1:0]         w_cquad [0:CORDIC_CELLS];

    assign w_ctok[0]  = r_c0_tok;
    assign w_cx[0]    = CORDIC_X0;
    assign w_cy[0]    = '0;
    assign w_cz[0]    = r_c0_z;
    assign w_cquad[0] = r_c0_quad;

    for (genvar g = 0; g < CORDIC_CELLS; g++) begin : g_cordic
        uvs_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_stage (5'(g)),
            .i_tok   (w_ctok[g]),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .i_quad  (w_cquad[g]),
            .o_tok   (w_ctok[g+1]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1]),
            .o_quad  (w_cquad[g+1])
        );
    end

    // fold the quadrant back
    t_token             w_ftok;
    logic signed [32:0] w_fx;
    logic signed [32:0] w_fy;
    logic signed [32:0] w_c33;
    logic signed [32:0] w_s33;
    logic signed [31:0] w_cos;
    logic signed [31:0] w_sin;

    assign w_ftok = w_ctok[CORDIC_CELLS];
    assign w_fx   = w_cx[CORDIC_CELLS];
    assign w_fy   = w_cy[CORDIC_CELLS];

    always_comb begin
        unique case (w_cquad[CORDIC_CELLS])
            2'd0:    begin w_c33 = w_fx;  w_s33 = w_fy;  end
            2'd1:    begin w_c33 = -w_fy; w_s33 = w_fx;  end
            2'd2:    begin w_c33 = -w_fx; w_s33 = -w_fy; end
            default: begin w_c33 = w_fy;  w_s33 = -w_fx; end
        endcase
        w_cos = w_c33[31:0];
        w_sin = w_s33[31:0];
    end

    // gather the four angles, then hand the set to the corner issue
    logic signed [31:0] r_lc0, r_ls0, r_lc1, r_ls1, r_sc0, r_ss0;
    logic signed [31:0] r_e_lc0, r_e_ls0, r_e_lc1, r_e_ls1;
    logic signed [31:0] r_e_sc0, r_e_ss0, r_e_sc1, r_e_ss1;
    logic               r_e_busy;
    logic               r_e_err;
    logic [2:0]         r_e_cnt;
    logic               w_load;

    assign w_load = w_ftok.valid && (w_ftok.tag == TAG_SLICE1);

    always_ff @(posedge i_clk) begin
        if (w_adv && w_ftok.valid) begin
            unique case (w_ftok.tag)
                TAG_LAYER0: begin r_lc0 <= w_cos; r_ls0 <= w_sin; end
                TAG_LAYER1: begin r_lc1 <= w_cos; r_ls1 <= w_sin; end
                TAG_SLICE0: begin r_sc0 <= w_cos; r_ss0 <= w_sin; end
                TAG_SLICE1: begin
                    r_e_lc0 <= r_lc0;
                    r_e_ls0 <= r_ls0;
                    r_e_lc1 <= r_lc1;
                    r_e_ls1 <= r_ls1;
                    r_e_sc0 <= r_sc0;
                    r_e_ss0 <= r_ss0;
                    r_e_sc1 <= w_cos;
                    r_e_ss1 <= w_sin;
                    r_e_err <= w_ftok.err;
                end
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_busy <= 1'b0;
            r_e_cnt  <= 3'd0;
        end else if (w_adv) begin
            if (w_load) begin
                r_e_busy <= 1'b1;
                r_e_cnt  <= 3'd0;
            end else if (r_e_busy) begin
                if (r_e_err || (r_e_cnt == 3'(LAST_CORNER))) begin
                    r_e_busy <= 1'b0;
                end else begin
                    r_e_cnt <= r_e_cnt + 3'd1;
                end
            end
        end
    end

    // corner products
    logic               w_a;
    logic               w_b;
    logic signed [31:0] w_lsel_c, w_lsel_s, w_ssel_c, w_ssel_s;
    t_meta              r_m1;
    logic signed [63:0] r_p0;
    logic signed [63:0] r_p1;
    logic signed [32:0] r_m1_u2;

    always_comb begin
        w_a      = corner_layer_hi(r_e_cnt);
        w_b      = corner_slice_hi(r_e_cnt);
        w_lsel_c = w_a ? r_e_lc1 : r_e_lc0;
        w_lsel_s = w_a ? r_e_ls1 : r_e_ls0;
        w_ssel_c = w_b ? r_e_sc1 : r_e_sc0;
        w_ssel_s = w_b ? r_e_ss1 : r_e_ss0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= '0;
        end else if (w_adv) begin
            r_m1.valid  <= r_e_busy;
            r_m1.corner <= r_e_err ? 3'd0 : r_e_cnt;
            r_m1.last   <= r_e_err || (r_e_cnt == 3'(LAST_CORNER));
            r_m1.err    <= r_e_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p0    <= w_lsel_s * w_ssel_c;
            r_p1    <= w_lsel_s * w_ssel_s;
            r_m1_u2 <= -33'(w_lsel_c);
        end
    end

    // unit vector and normals
    t_meta              r_m2;
    logic signed [32:0] r_u0, r_u1, r_u2;
    logic signed [15:0] r_n0, r_n1, r_n2;
    logic signed [32:0] w_u0, w_u1;

    assign w_u0 = 33'((r_p0 + 64'sd536870912) >>> 30);
    assign w_u1 = 33'((r_p1 + 64'sd536870912) >>> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2 <= '0;
        end else if (w_adv) begin
            r_m2 <= r_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u0 <= w_u0;
            r_u1 <= w_u1;
            r_u2 <= r_m1_u2;
            r_n0 <= norm_of(w_u0);
            r_n1 <= norm_of(w_u1);
            r_n2 <= norm_of(r_m1_u2);
        end
    end

    // scale by radius
    t_meta              r_m3;
    logic signed [49:0] r_q0, r_q1, r_q2;
    logic signed [15:0] r_m3_n0, r_m3_n1, r_m3_n2;
    logic signed [16:0] w_rad;

    assign w_rad = signed'({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3 <= '0;
        end else if (w_adv) begin
            r_m3 <= r_m2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q0    <= w_rad * r_u0;
            r_q1    <= w_rad * r_u1;
            r_q2    <= w_rad * r_u2;
            r_m3_n0 <= r_n0;
            r_m3_n1 <= r_n1;
            r_m3_n2 <= r_n2;
        end
    end

    t_result w_res;

    always_comb begin
        w_res.px     = r_m3.err ? '0 : pos_of(r_q0);
        w_res.py     = r_m3.err ? '0 : pos_of(r_q1);
        w_res.pz     = r_m3.err ? '0 : pos_of(r_q2);
        w_res.nx     = r_m3.err ? '0 : r_m3_n0;
        w_res.ny     = r_m3.err ? '0 : r_m3_n1;
        w_res.nz     = r_m3.err ? '0 : r_m3_n2;
        w_res.corner = r_m3.corner;
        w_res.last   = r_m3.last;
        w_res.err    = r_m3.err;
    end

    // output register with skid stage
    logic w_take;

    assign w_take = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            r_out_v <= r_m3.valid;
        end else begin
            r_skid_v <= r_m3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || w_take) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {2'b00, r_out.corner, r_out.nz, r_out.ny, r_out.nx,
                         r_out.pz, r_out.py, r_out.px};
    assign o_m_tuser  = r_out.err;
    assign o_m_tlast  = r_out.last;

endmodule

### tb/sv/uv_sphere_cell_vertex_checker.sv
module uv_sphere_cell_vertex_checker
    import uvs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [15:0]  i_s_tdata,   // layer_index[7:0], slice_index[15:8]
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // pos_x pos_y pos_z normal_x normal_y normal_z corner_number, zero fill
    input  logic [103:0] i_m_tdata,
    input  logic         i_m_tuser,   // range_error
    input  logic         i_m_tlast,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_vertices_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic [2:0]         corner;
        logic               last;
        logic               err;
    } t_vertex;

    localparam longint ARCTAN_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    logic [15:0] radius_q88;
    logic [8:0]  slices;
    logic [8:0]  layers;
    t_vertex     vertex_q[$];

    function automatic longint round_half_up(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // cos and sin of a phase where 2^32 is one turn, both Q2.30
    function automatic void phase_sincos(logic [31:0] phase, output longint c,
                                         output longint s);
        logic [1:0] quad;
        longint z, x, y, nx, ny;
        quad = phase[31:30];
        z = longint'(phase[29:0]);
        x = 652032874;
        y = 0;
        if (z >= (64'sd1 <<< 29)) begin
            z = z - (64'sd1 <<< 30);
            quad = quad + 2'd1;
        end
        for (int i = 0; i < CORDIC_CELLS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ARCTAN_TURN[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ARCTAN_TURN[i];
            end
            x = nx;
            y = ny;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    task automatic queue_cell_corners(logic [7:0] layer, logic [7:0] slice);
        longint lat_c [2], lat_s [2], lon_c [2], lon_s [2];
        longint unit [3];
        logic [63:0] lp, sp;
        t_vertex v;
        int a, b;
        if (layer >= layers || slice >= slices) begin
            v = '0;
            v.last = 1'b1;
            v.err = 1'b1;
            vertex_q.push_back(v);
            return;
        end
        for (int k = 0; k < 2; k++) begin
            lp = ((64'(layer) + k) << 31) / layers;
            sp = ((64'(slice) + k) << 32) / slices;
            phase_sincos(lp[31:0], lat_c[k], lat_s[k]);
            phase_sincos(sp[31:0], lon_c[k], lon_s[k]);
        end
        for (int k = 0; k < 6; k++) begin
            a = (k == 2 || k == 4 || k == 5) ? 1 : 0;
            b = (k == 1 || k == 2 || k == 4) ? 1 : 0;
            unit[0] = round_half_up(lat_s[a] * lon_c[b], 30);
            unit[1] = round_half_up(lat_s[a] * lon_s[b], 30);
            unit[2] = -lat_c[a];
            v.pos_x = 17'(sat(round_half_up(longint'(radius_q88) * unit[0], 30), 65535));
            v.pos_y = 17'(sat(round_half_up(longint'(radius_q88) * unit[1], 30), 65535));
            v.pos_z = 17'(sat(round_half_up(longint'(radius_q88) * unit[2], 30), 65535));
            v.nrm_x = 16'(sat(round_half_up(unit[0], 16), 16384));
            v.nrm_y = 16'(sat(round_half_up(unit[1], 16), 16384));
            v.nrm_z = 16'(sat(round_half_up(unit[2], 16), 16384));
            v.corner = 3'(k);
            v.last = (k == 5);
            v.err = 1'b0;
            vertex_q.push_back(v);
        end
    endtask

    task automatic report(string field, longint got, longint want);
        $display("[%0t] vertex %0d: %s is %0d, want %0d", $realtime, o_vertices_seen,
                 field, got, want);
        o_fail_count++;
    endtask

    assign o_pending = vertex_q.size();

    always @(posedge i_clk) begin
        t_vertex got, want;
        if (!i_rst_n) begin
            radius_q88 = 16'd256;
            slices = 9'd16;
            layers = 9'd16;
            o_fail_count = 0;
            o_vertices_seen = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RADIUS: radius_q88 = i_cfg_wdata;
                    REG_SLICES: slices = i_cfg_wdata[8:0];
                    REG_LAYERS: layers = i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                queue_cell_corners(i_s_tdata[7:0], i_s_tdata[15:8]);
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[16:0], i_m_tdata[33:17], i_m_tdata[50:34],
                       i_m_tdata[66:51], i_m_tdata[82:67], i_m_tdata[98:83],
                       i_m_tdata[101:99], i_m_tlast, i_m_tuser};
                if (vertex_q.size() == 0) begin
                    report("unexpected item, corner", got.corner, -1);
                end else begin
                    want = vertex_q.pop_front();
                    if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
                    if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
                    if (got.nrm_x !== want.nrm_x) report("normal_x", got.nrm_x, want.nrm_x);
                    if (got.nrm_y !== want.nrm_y) report("normal_y", got.nrm_y, want.nrm_y);
                    if (got.nrm_z !== want.nrm_z) report("normal_z", got.nrm_z, want.nrm_z);
                    if (got.corner !== want.corner)
                        report("corner_number", got.corner, want.corner);
                    if (got.last !== want.last) report("last_corner", got.last, want.last);
                    if (got.err !== want.err) report("range_error", got.err, want.err);
                end
                o_vertices_seen++;
            end
        end
    end
endmodule

### tb/sv/uv_sphere_cell_vertex_generator_unit_test.sv
module uv_sphere_cell_vertex_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import uvs_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = REG_RADIUS;
    logic [15:0]  cfg_wdata = '0;
    logic         cell_valid = 1'b0;
    logic         cell_ready;
    logic [15:0]  cell_data = '0;
    logic         vtx_valid;
    logic         vtx_ready = 1'b0;
    logic [103:0] vtx_data;
    logic         vtx_err;
    logic         vtx_last;
    int           fail_count, pending, vertices_seen;
    int           sender_idle_pct = 17, receiver_idle_pct = 77;
    int           cells_sent = 0, quiet_cycles = 0;
    logic [8:0]   cur_slices = 9'd16, cur_layers = 9'd16;

    always #5 i_clk = ~i_clk;

    uv_sphere_cell_vertex_generator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(cell_valid), .o_s_tready(cell_ready), .i_s_tdata(cell_data),
        .o_m_tvalid(vtx_valid), .i_m_tready(vtx_ready), .o_m_tdata(vtx_data),
        .o_m_tuser(vtx_err), .o_m_tlast(vtx_last)
    );

    uv_sphere_cell_vertex_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(cell_valid), .i_s_tready(cell_ready), .i_s_tdata(cell_data),
        .i_m_tvalid(vtx_valid), .i_m_tready(vtx_ready), .i_m_tdata(vtx_data),
        .i_m_tuser(vtx_err), .i_m_tlast(vtx_last),
        .o_fail_count(fail_count), .o_pending(pending), .o_vertices_seen(vertices_seen)
    );

    always @(posedge i_clk)
        vtx_ready <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge i_clk) begin
        if ((cell_valid && cell_ready) || (vtx_valid && vtx_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays high between back-to-back cells
    task automatic send_cell(logic [7:0] layer, logic [7:0] slice);
        while ($urandom_range(99) < sender_idle_pct) begin
            cell_valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_valid <= 1'b1;
        cell_data <= {slice, layer};
        do @(posedge i_clk); while (!cell_ready);
        cells_sent++;
    endtask

    task automatic drain();
        cell_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] radius, logic [15:0] slices, logic [15:0] layers);
        cfg_we <= 1'b1;
        cfg_addr <= REG_RADIUS;
        cfg_wdata <= radius;
        @(posedge i_clk);
        cfg_addr <= REG_SLICES;
        cfg_wdata <= slices;
        @(posedge i_clk);
        cfg_addr <= REG_LAYERS;
        cfg_wdata <= layers;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_slices = slices[8:0];
        cur_layers = layers[8:0];
    endtask

    // mostly cells inside the grid, some beyond it
    task automatic random_cells(int n);
        logic [7:0] l, s;
        for (int i = 0; i < n; i++) begin
            l = $urandom_range(255);
            s = $urandom_range(255);
            if ($urandom_range(99) < 85) begin
                if (cur_layers != 0)
                    l = $urandom_range((cur_layers > 256 ? 256 : cur_layers) - 1);
                if (cur_slices != 0)
                    s = $urandom_range((cur_slices > 256 ? 256 : cur_slices) - 1);
            end
            send_cell(l, s);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // poles, seams, grid edges and cells past the counts
        send_cell(8'd0, 8'd0);
        send_cell(8'd15, 8'd15);
        send_cell(8'd0, 8'd15);
        send_cell(8'd15, 8'd0);
        send_cell(8'd7, 8'd3);
        send_cell(8'd8, 8'd8);
        send_cell(8'd16, 8'd0);
        send_cell(8'd0, 8'd16);
        send_cell(8'd255, 8'd255);
        send_cell(8'd4, 8'd12);
        drain();
        write_regs(16'hFFFF, 16'd256, 16'd256);
        send_cell(8'd0, 8'd0);
        send_cell(8'd255, 8'd255);
        send_cell(8'd128, 8'd64);
        send_cell(8'd127, 8'd192);
        send_cell(8'hAA, 8'h55);
        send_cell(8'h55, 8'hAA);
        random_cells(100);
        drain();

        sender_idle_pct = 77;
        receiver_idle_pct = 17;
        write_regs(16'd0, 16'd1, 16'd1);
        send_cell(8'd0, 8'd0);
        send_cell(8'd1, 8'd0);
        random_cells(25);
        drain();
        write_regs(16'd300, 16'd511, 16'd3);
        random_cells(55);
        drain();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_regs(16'd40000, 16'd7, 16'd0);
        random_cells(15);
        drain();
        write_regs(16'd256, 16'd256, 16'd256);
        random_cells(110);
        drain();

        $display("cells sent: %0d, vertex items checked: %0d", cells_sent, vertices_seen);
        $display("covered radius 0 to full scale, counts 0, 1, 3, 7, 16, 256 and 511");
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### files.f
rtl/uvs_pkg.sv
rtl/uvs_div_cell.sv
rtl/uvs_cordic_cell.sv
rtl/uv_sphere_cell_vertex_generator_unit.sv
tb/sv/uv_sphere_cell_vertex_checker.sv
tb/sv/uv_sphere_cell_vertex_generator_unit_test.sv
